/* rtl/core/ipv4rx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipv4rx_pkg
// Shared types and constants for the IPv4 receive header check.
// -----------------------------------------------------------------------------
package ipv4rx_pkg;

   // fixed header geometry and field constants
   localparam logic [15:0] HDR_BYTES  = 16'd20;
   localparam logic [15:0] FRAG_MASK  = 16'hbfff;
   localparam logic [15:0] SUM_GOOD   = 16'hffff;
   localparam logic [15:0] COUNT_MAX  = 16'hffff;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;

   // register file geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes (paddr bit 2)
   typedef enum logic {
      REG_LOCAL_ADDRESS     = 1'b0,
      REG_VALIDATE_CHECKSUM = 1'b1
   } reg_index_type;

   // verdict codes
   typedef enum logic [2:0] {
      ST_TCP   = 3'd0,
      ST_UDP   = 3'd1,
      ST_SMALL = 3'd2,
      ST_BADLEN = 3'd3,
      ST_FRAG  = 3'd4,
      ST_DEST  = 3'd5,
      ST_CSUM  = 3'd6,
      ST_PROTO = 3'd7
   } status_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [31:0] local_address;
      logic        validate_checksum;
   } cfg_type;

   // frame state after the current byte is taken in
   typedef struct packed {
      logic [15:0] byte_count;
      logic [15:0] header_sum;
      logic [15:0] total_length;
      logic [15:0] flags_offset;
      logic [7:0]  protocol;
      logic [31:0] source;
      logic [31:0] destination;
   } frame_type;

endpackage
`default_nettype wire

/* rtl/core/ipv4rx_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipv4rx_csr
// APB-style register file: local address and checksum enable.
// -----------------------------------------------------------------------------
module ipv4rx_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [ipv4rx_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [ipv4rx_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [ipv4rx_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                        csr_pready,
   output ipv4rx_pkg::cfg_type                         cfg
);

   logic [31:0]               local_ff;
   logic [31:0]               local_in;
   logic                      validate_ff;
   logic                      validate_in;
   logic                      wr_en;
   ipv4rx_pkg::reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = ipv4rx_pkg::reg_index_type'(csr_paddr[2]);

   // register write decode
   always_comb begin
      local_in    = local_ff;
      validate_in = validate_ff;
      if (wr_en) begin
         case (idx)
            ipv4rx_pkg::REG_LOCAL_ADDRESS:     local_in    = csr_pwdata;
            ipv4rx_pkg::REG_VALIDATE_CHECKSUM: validate_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ff    <= '0;
         validate_ff <= 1'b1;
      end else begin
         local_ff    <= local_in;
         validate_ff <= validate_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         ipv4rx_pkg::REG_LOCAL_ADDRESS:     csr_prdata = local_ff;
         ipv4rx_pkg::REG_VALIDATE_CHECKSUM: csr_prdata = {31'd0, validate_ff};
         default:                           csr_prdata = '0;
      endcase
   end

   assign cfg.local_address     = local_ff;
   assign cfg.validate_checksum = validate_ff;

endmodule
`default_nettype wire

/* rtl/core/ipv4rx_accum.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipv4rx_accum
// Per-frame state: byte count, folded header sum and latched header fields.
// -----------------------------------------------------------------------------
module ipv4rx_accum (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  last_byte,
   output ipv4rx_pkg::frame_type      frame_next
);

   ipv4rx_pkg::frame_type frame_ff;
   ipv4rx_pkg::frame_type frame_in;
   logic [7:0]            pend_ff;
   logic [7:0]            pend_in;
   logic [7:0]            pend_next;
   logic [4:0]            pos;
   logic                  in_hdr;
   logic [16:0]           sum_wide;
   logic [15:0]           sum_fold;

   assign pos    = frame_ff.byte_count[4:0];
   assign in_hdr = frame_ff.byte_count < ipv4rx_pkg::HDR_BYTES;

   // ones'-complement add with end-around carry
   assign sum_wide = {1'b0, frame_ff.header_sum} + {1'b0, pend_ff, data_byte};
   assign sum_fold = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];

   // state after this byte
   always_comb begin
      frame_next = frame_ff;
      pend_next  = pend_ff;
      if (frame_ff.byte_count != ipv4rx_pkg::COUNT_MAX) begin
         frame_next.byte_count = frame_ff.byte_count + 16'd1;
      end
      if (in_hdr) begin
         if (!pos[0]) begin
            pend_next = data_byte;
         end else begin
            frame_next.header_sum = sum_fold;
         end
         case (pos) inside
            5'd2, 5'd3:
               frame_next.total_length = {frame_ff.total_length[7:0], data_byte};
            5'd6, 5'd7:
               frame_next.flags_offset = {frame_ff.flags_offset[7:0], data_byte};
            5'd9:
               frame_next.protocol = data_byte;
            [5'd12:5'd15]:
               frame_next.source = {frame_ff.source[23:0], data_byte};
            [5'd16:5'd19]:
               frame_next.destination = {frame_ff.destination[23:0], data_byte};
            default: ;
         endcase
      end
   end

   // commit, clearing after the final byte of a frame
   always_comb begin
      frame_in = frame_ff;
      pend_in  = pend_ff;
      if (fire) begin
         if (last_byte) begin
            frame_in = '0;
            pend_in  = '0;
         end else begin
            frame_in = frame_next;
            pend_in  = pend_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         pend_ff  <= '0;
      end else begin
         frame_ff <= frame_in;
         pend_ff  <= pend_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/ipv4rx_result.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipv4rx_result
// Verdict logic and the result register toward the rsp channel.
// -----------------------------------------------------------------------------
module ipv4rx_result (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic                  last_byte,
   input  wire ipv4rx_pkg::frame_type frame_next,
   input  wire ipv4rx_pkg::cfg_type   cfg,
   output logic                       advance,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic [7:0]                 rsp_protocol,
   output logic [31:0]                rsp_source_address,
   output logic [15:0]                rsp_payload_length
);

   logic                   valid_ff;
   logic                   valid_in;
   ipv4rx_pkg::status_type status_ff;
   ipv4rx_pkg::status_type status_in;
   logic [7:0]             proto_ff;
   logic [31:0]            source_ff;
   logic [15:0]            payload_ff;
   logic [15:0]            payload_in;
   logic                   load;

   // result slot frees when empty or being taken
   assign advance = !(valid_ff && rsp_stall);
   assign load    = fire && last_byte;

   // checks in priority order
   always_comb begin
      payload_in = '0;
      if (frame_next.byte_count < ipv4rx_pkg::HDR_BYTES) begin
         status_in = ipv4rx_pkg::ST_SMALL;
      end else if (frame_next.total_length < ipv4rx_pkg::HDR_BYTES ||
                   frame_next.total_length > frame_next.byte_count) begin
         status_in = ipv4rx_pkg::ST_BADLEN;
      end else begin
         payload_in = frame_next.total_length - ipv4rx_pkg::HDR_BYTES;
         if ((frame_next.flags_offset & ipv4rx_pkg::FRAG_MASK) != 16'd0) begin
            status_in = ipv4rx_pkg::ST_FRAG;
         end else if (frame_next.destination != cfg.local_address) begin
            status_in = ipv4rx_pkg::ST_DEST;
         end else if (cfg.validate_checksum &&
                      frame_next.header_sum != ipv4rx_pkg::SUM_GOOD) begin
            status_in = ipv4rx_pkg::ST_CSUM;
         end else if (frame_next.protocol == ipv4rx_pkg::PROTO_TCP) begin
            status_in = ipv4rx_pkg::ST_TCP;
         end else if (frame_next.protocol == ipv4rx_pkg::PROTO_UDP) begin
            status_in = ipv4rx_pkg::ST_UDP;
         end else begin
            status_in = ipv4rx_pkg::ST_PROTO;
         end
      end
   end

   // result valid flag
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff  <= status_in;
         proto_ff   <= frame_next.protocol;
         source_ff  <= frame_next.source;
         payload_ff <= payload_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_protocol       = proto_ff;
   assign rsp_source_address = source_ff;
   assign rsp_payload_length = payload_ff;

endmodule
`default_nettype wire

/* rtl/core/ipv4_receive_header_check.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipv4_receive_header_check
// Byte-wide IPv4 header check: sums and latches the 20-byte header and
// gives one verdict per frame on its last byte.
//
//   channel  direction  payload                                   handshake
//   req      in         data_byte, last_byte                      valid/stall
//   rsp      out        status, protocol, source_address,
//                       payload_length                            valid/stall
//   csr      in/out     local_address (0x0), validate_checksum    APB-style
//
// One byte per cycle while rsp does not stall; each byte waits in the input
// register, and the verdict enters the result register as the last byte fires.
// Throughput is set by the single accumulate step on the frame state.
// Synchronous reset clears the frame state, the valid flags and the
// registers (checksum checking on). A stalled result holds the input
// register, and req_stall rises only while both stages are full.
// -----------------------------------------------------------------------------
module ipv4_receive_header_check (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_data_byte,
   input  wire logic                               req_last_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [2:0]                              rsp_status,
   output logic [7:0]                              rsp_protocol,
   output logic [31:0]                             rsp_source_address,
   output logic [15:0]                             rsp_payload_length,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [ipv4rx_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ipv4rx_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [ipv4rx_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                    csr_pready
);

   ipv4rx_pkg::cfg_type   cfg;
   ipv4rx_pkg::frame_type frame_next;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  advance;
   logic                  fire;
   logic                  accept;

   // input register handshake
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign fire      = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // byte transfer capture
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   ipv4rx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ipv4rx_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .frame_next (frame_next)
   );

   ipv4rx_result u_result (
      .clock              (clock),
      .reset              (reset),
      .fire               (fire),
      .last_byte          (in_last_ff),
      .frame_next         (frame_next),
      .cfg                (cfg),
      .advance            (advance),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_protocol       (rsp_protocol),
      .rsp_source_address (rsp_source_address),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule
`default_nettype wire
